>>> design/binned_variogram_accumulator_top_assert.svh
// Assertion macros for the binned variogram accumulator.
`ifndef BINNED_VARIOGRAM_ACCUMULATOR_TOP_ASSERT_SVH
`define BINNED_VARIOGRAM_ACCUMULATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BVA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define BVA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BVA_ASSERT_NOW(lbl, ante, cons, msg)
`define BVA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/bva_pkg.sv
// Shared types and constants for the binned variogram accumulator.
package bva_pkg;

    localparam int LAG_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 24;
    localparam int SUM_W    = 48;
    localparam int BIN_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NB_W     = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_MOMENT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LAG     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAG     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD,
        ST_DRD,
        ST_DCAP,
        ST_DOUT
    } state_t;

endpackage

>>> design/binned_variogram_accumulator_top.sv
// Top level of the binned variogram accumulator: config, bin store and dump sequencer.
// Each accepted pair is handled alone: the bin index (lag - min_lag) / lag_step
// comes from a restoring divider, then one read-modify-write of the bin
// store. Only one pair is in flight; s_ready is high only while the block is idle.
// A pair marked end_of_set is accumulated first, then the bins in use are emitted
// in bin order, one beat per bin, each going through a memory read, a capture and a
// handshake, plus any stall on m_ready. The store is a MAX_BINS-entry
// memory of count and sum with a valid flag per entry; the flags are cleared at
// reset and after the last beat of a dump, so no clearing pass is needed.
module binned_variogram_accumulator_top #(
    parameter int MAX_BINS = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    input  logic                                    cfg_wr_en,
    input  logic [bva_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [bva_pkg::CFG_DATA_W-1:0]          cfg_data,

    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [bva_pkg::LAG_W-1:0]               s_lag_distance,
    input  logic signed [bva_pkg::SAMPLE_W-1:0]     s_sample_first,
    input  logic signed [bva_pkg::SAMPLE_W-1:0]     s_sample_second,
    input  logic                                    s_end_of_set,

    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [bva_pkg::BIN_W-1:0]               m_bin_number,
    output logic [bva_pkg::LAG_W-1:0]               m_bin_lower_edge,
    output logic [bva_pkg::COUNT_W-1:0]             m_pair_count,
    output logic [bva_pkg::SUM_W-1:0]               m_moment_sum,
    output logic                                    m_last_bin
);

`include "binned_variogram_accumulator_top_assert.svh"

    localparam int AW     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int ENTRY_W = bva_pkg::SUM_W + bva_pkg::COUNT_W;
    localparam int DIFF_W = bva_pkg::SAMPLE_W + 1;
    localparam int INC_W  = 2 * bva_pkg::SAMPLE_W;
    localparam int NB_W   = bva_pkg::NB_W;

    // configuration
    logic                           moment_mode_reg;
    logic [bva_pkg::LAG_W-1:0]      min_lag_reg;
    logic [bva_pkg::LAG_W-1:0]      lag_step_reg;
    logic [bva_pkg::LAG_W-1:0]      max_lag_reg;
    logic [5:0]                     bins_in_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            moment_mode_reg <= 1'b0;
            min_lag_reg     <= '0;
            lag_step_reg    <= 16'd1;
            max_lag_reg     <= 16'hFFFF;
            bins_in_use_reg <= 6'd32;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bva_pkg::CFG_MOMENT_MODE: moment_mode_reg <= cfg_data[0];
                bva_pkg::CFG_MIN_LAG:     min_lag_reg     <= cfg_data;
                bva_pkg::CFG_LAG_STEP:    lag_step_reg    <= cfg_data;
                bva_pkg::CFG_MAX_LAG:     max_lag_reg     <= cfg_data;
                bva_pkg::CFG_BINS_IN_USE: bins_in_use_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // effective bin count, clamped to 1..MAX_BINS
    logic [NB_W-1:0] nb;
    always_comb begin
        nb = NB_W'(bins_in_use_reg);
        if (bins_in_use_reg == 6'd0) begin
            nb = NB_W'(1);
        end else if (NB_W'(bins_in_use_reg) > NB_W'(MAX_BINS)) begin
            nb = NB_W'(MAX_BINS);
        end
    end

    // control
    bva_pkg::state_t state_reg, state_next;

    logic                        div_start;
    logic                        div_done;
    logic [bva_pkg::LAG_W-1:0]   div_quotient;
    logic                        hit;
    logic [AW-1:0]               rd_addr;
    logic                        mem_we;
    logic                        dump_begin;
    logic                        load_out;
    logic                        advance;
    logic                        clear_all;
    logic                        is_last_bin;

    logic                        last_reg;
    logic                        pair_ok_reg;
    logic signed [DIFF_W-1:0]    diff_reg;
    logic [INC_W-1:0]            inc_reg;
    logic [AW-1:0]               upd_addr_reg;
    logic [AW-1:0]               dump_idx_reg;
    logic [bva_pkg::LAG_W:0]     edge_reg;

    logic [ENTRY_W-1:0]          mem [MAX_BINS];
    logic [MAX_BINS-1:0]         entry_valid_reg;
    logic [ENTRY_W-1:0]          rd_data_reg;
    logic                        rd_live_reg;

    assign hit = pair_ok_reg && (div_quotient < bva_pkg::LAG_W'(nb));
    assign is_last_bin = ((NB_W'(dump_idx_reg) + NB_W'(1)) == nb);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bva_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        rd_addr    = dump_idx_reg;
        mem_we     = 1'b0;
        dump_begin = 1'b0;
        load_out   = 1'b0;
        advance    = 1'b0;
        clear_all  = 1'b0;
        unique case (state_reg)
            bva_pkg::ST_IDLE: begin
                if (s_valid) begin
                    div_start  = 1'b1;
                    state_next = bva_pkg::ST_DIV;
                end
            end
            bva_pkg::ST_DIV: begin
                if (div_done) begin
                    if (hit) begin
                        rd_addr    = div_quotient[AW-1:0];
                        state_next = bva_pkg::ST_UPD;
                    end else if (last_reg) begin
                        dump_begin = 1'b1;
                        state_next = bva_pkg::ST_DRD;
                    end else begin
                        state_next = bva_pkg::ST_IDLE;
                    end
                end
            end
            bva_pkg::ST_UPD: begin
                mem_we = 1'b1;
                if (last_reg) begin
                    dump_begin = 1'b1;
                    state_next = bva_pkg::ST_DRD;
                end else begin
                    state_next = bva_pkg::ST_IDLE;
                end
            end
            bva_pkg::ST_DRD: begin
                state_next = bva_pkg::ST_DCAP;
            end
            bva_pkg::ST_DCAP: begin
                load_out   = 1'b1;
                state_next = bva_pkg::ST_DOUT;
            end
            bva_pkg::ST_DOUT: begin
                if (m_ready) begin
                    if (is_last_bin) begin
                        clear_all  = 1'b1;
                        state_next = bva_pkg::ST_IDLE;
                    end else begin
                        advance    = 1'b1;
                        state_next = bva_pkg::ST_DRD;
                    end
                end
            end
            default: state_next = bva_pkg::ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == bva_pkg::ST_IDLE);
    assign m_valid = (state_reg == bva_pkg::ST_DOUT);

    bva_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_lag_distance - min_lag_reg),
        .divisor  (lag_step_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // moment increment, registered after the multiplier
    logic [DIFF_W-1:0]           abs_wide;
    logic [bva_pkg::SAMPLE_W-1:0] abs_d;
    assign abs_wide = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
    assign abs_d    = abs_wide[bva_pkg::SAMPLE_W-1:0];

    always_ff @(posedge aclk) begin
        if (div_start) begin
            diff_reg    <= DIFF_W'(s_sample_first) - DIFF_W'(s_sample_second);
            last_reg    <= s_end_of_set;
            pair_ok_reg <= (s_lag_distance <= max_lag_reg) &&
                           (s_lag_distance >= min_lag_reg) &&
                           (lag_step_reg != '0);
        end
        if (state_reg == bva_pkg::ST_DIV) begin
            inc_reg <= moment_mode_reg ? INC_W'(abs_d) : abs_d * abs_d;
        end
        if (div_done) begin
            upd_addr_reg <= div_quotient[AW-1:0];
        end
    end

    // saturating update of the entry just read
    logic [bva_pkg::SUM_W-1:0]   cur_sum;
    logic [bva_pkg::COUNT_W-1:0] cur_cnt;
    logic [bva_pkg::SUM_W:0]     sum_wide;
    logic [bva_pkg::SUM_W-1:0]   new_sum;
    logic [bva_pkg::COUNT_W-1:0] new_cnt;

    assign cur_sum  = rd_live_reg ? rd_data_reg[ENTRY_W-1:bva_pkg::COUNT_W] : '0;
    assign cur_cnt  = rd_live_reg ? rd_data_reg[bva_pkg::COUNT_W-1:0] : '0;
    assign sum_wide = {1'b0, cur_sum} + (bva_pkg::SUM_W + 1)'(inc_reg);
    assign new_sum  = sum_wide[bva_pkg::SUM_W] ? '1 : sum_wide[bva_pkg::SUM_W-1:0];
    assign new_cnt  = (cur_cnt == '1) ? cur_cnt : cur_cnt + bva_pkg::COUNT_W'(1);

    // bin store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[upd_addr_reg] <= {new_sum, new_cnt};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            rd_live_reg     <= 1'b0;
        end else begin
            rd_live_reg <= entry_valid_reg[rd_addr];
            if (clear_all) begin
                entry_valid_reg <= '0;
            end else if (mem_we) begin
                entry_valid_reg[upd_addr_reg] <= 1'b1;
            end
        end
    end

    // dump sequencer datapath
    logic [bva_pkg::LAG_W+1:0] edge_sum;
    assign edge_sum = {1'b0, edge_reg} + (bva_pkg::LAG_W + 2)'(lag_step_reg);

    always_ff @(posedge aclk) begin
        if (dump_begin) begin
            dump_idx_reg <= '0;
            edge_reg     <= (bva_pkg::LAG_W + 1)'(min_lag_reg);
        end else if (advance) begin
            dump_idx_reg <= dump_idx_reg + AW'(1);
            edge_reg     <= (edge_sum > (bva_pkg::LAG_W + 2)'(16'hFFFF)) ?
                            {1'b1, {bva_pkg::LAG_W{1'b0}}} : edge_sum[bva_pkg::LAG_W:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_bin_number     <= bva_pkg::BIN_W'(dump_idx_reg);
            m_bin_lower_edge <= edge_reg[bva_pkg::LAG_W] ? '1 : edge_reg[bva_pkg::LAG_W-1:0];
            m_pair_count     <= cur_cnt;
            m_moment_sum     <= cur_sum;
            m_last_bin       <= is_last_bin;
        end
    end

    `BVA_ASSERT_NOW(a_idle_no_result, s_ready, !m_valid, "input taken while a result is shown")
    `BVA_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "second pair taken while busy")
    `BVA_ASSERT_NOW(a_dump_in_range, m_valid, NB_W'(dump_idx_reg) < nb, "dump index past bins in use")
    `BVA_ASSERT_NEXT(a_clear_after_dump, m_valid && m_ready && m_last_bin,
        entry_valid_reg == '0, "store not cleared after dump")

endmodule

>>> design/bva_divider.sv
// Restoring divider, one quotient bit per cycle, for the lag bin index.
module bva_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [bva_pkg::LAG_W-1:0]     dividend,
    input  logic [bva_pkg::LAG_W-1:0]     divisor,
    output logic                          done,
    output logic [bva_pkg::LAG_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(bva_pkg::LAG_W);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [bva_pkg::LAG_W-1:0]     rem_reg;
    logic [bva_pkg::LAG_W-1:0]     quo_reg;
    logic [bva_pkg::LAG_W:0]       shifted;
    logic [bva_pkg::LAG_W:0]       diff;
    logic                          fits;

    assign shifted = {rem_reg, quo_reg[bva_pkg::LAG_W-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign fits    = (shifted >= {1'b0, divisor});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(bva_pkg::LAG_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[bva_pkg::LAG_W-1:0] : shifted[bva_pkg::LAG_W-1:0];
            quo_reg <= {quo_reg[bva_pkg::LAG_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
